>>> rtl/core/res_pkg.sv
`timescale 1ns / 1ps

package res_pkg;

  // Operation codes of an input request
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_WRITE = 3'd1,
    OP_START = 3'd2,
    OP_PULSE = 3'd3,
    OP_CLEAR = 3'd4
  } op_e;

  // Channel state as reported in a result
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_SW_OFF = 2'd2,
    MODE_SW_ON  = 2'd3
  } mode_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CHAN = 2'd1,
    ST_EXEC = 2'd2
  } state_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE_MASK  = 2'd0;
  localparam logic [1:0] CFG_SUPPRESS_ALL = 2'd1;
  localparam logic [1:0] CFG_TICK_MS      = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Field widths
  localparam int unsigned DUR_W = 16;
  localparam int unsigned STR_W = 13;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned REM_W = 17;
  localparam int unsigned LVL_W = 9;
  localparam int unsigned ENT_W = DUR_W + STR_W;

  // Q12 thresholds: full scale, high motor (0.8), switch on (0.05)
  localparam logic [STR_W-1:0] STR_FULL = 13'd4096;
  localparam logic [STR_W-1:0] STR_HIGH = 13'd3276;
  localparam logic [STR_W-1:0] STR_ON   = 13'd204;

  // Level scaling: 1275 * i, minus 1275 * 4096 / 5 above the high threshold
  localparam int unsigned PROD_W = 23;
  localparam logic [PROD_W-1:0] LEVEL_MUL   = 23'd1275;
  localparam logic [PROD_W-1:0] HIGH_OFFSET = 23'd1044480;
  localparam logic [PROD_W-1:0] LEVEL_MAX   = 23'd255;

  // Actuator bytes for an intensity: {high motor, level}
  function automatic logic [LVL_W-1:0] levels_for(logic [STR_W-1:0] s);
    logic [STR_W-1:0]  i;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] lvl;
    logic              high;
    i    = (s > STR_FULL) ? STR_FULL : s;
    prod = PROD_W'(i) * LEVEL_MUL;
    high = (s > STR_HIGH);
    if (high) begin
      lvl = (prod - HIGH_OFFSET) >> 14;
    end else begin
      lvl = prod >> 14;
    end
    if (lvl > LEVEL_MAX) begin
      lvl = LEVEL_MAX;
    end
    return {high, lvl[7:0]};
  endfunction

endpackage

>>> rtl/core/res_ram.sv
`timescale 1ns / 1ps

module res_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/rumble_envelope_sequencer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    operation_i .. accepted_i
// out       output     out_valid_o / out_ready_i  channel_o .. last_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A non-tick request passes through the channel and execute states and loads one
// result. A tick passes through both states once per channel, one result per channel.
// Each channel step is a read of the channel-state RAM followed by a dependent
// read of the envelope RAM; after the last result loads the sequencer returns to
// idle and takes the next request there.
// Reset clears per-channel valid bits, so channel records read as zero at once;
// the envelope store holds nothing defined until written. A held output
// register stalls the sequencer in its execute state; cfg writes are always taken.
module rumble_envelope_sequencer
  import res_pkg::*;
#(
  parameter int unsigned ENVELOPE_DEPTH = 16,
  parameter int unsigned CHANNELS       = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            operation_i,
  input  logic                  controller_i,
  input  logic [3:0]            entry_index_i,
  input  logic [DUR_W-1:0]      duration_ms_i,
  input  logic [STR_W-1:0]      strength_i,
  input  logic [CNT_W-1:0]      entry_count_i,
  input  logic [1:0]            pad_ready_i,
  input  logic [1:0]            accepted_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  channel_o,
  output logic                  send_o,
  output logic                  high_motor_o,
  output logic [7:0]            motor_level_o,
  output logic [1:0]            mode_o,
  output logic                  ignored_o,
  output logic                  last_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW     = (ENVELOPE_DEPTH > 1) ? $clog2(ENVELOPE_DEPTH) : 1;
  localparam int unsigned CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ENV_AW = CW + AW;

  typedef struct packed {
    mode_e              mode;
    logic [REM_W-1:0]   remaining;
    logic [STR_W-1:0]   strength;
    logic [CNT_W-1:0]   pending;
    logic [AW-1:0]      next_entry;
    logic               from_pulse;
    logic [DUR_W-1:0]   p_dur;
    logic [STR_W-1:0]   p_str;
    logic [LVL_W-1:0]   levels;
  } chan_rec_t;

  localparam int unsigned REC_W = $bits(chan_rec_t);

  // Configuration registers
  logic [1:0] enable_mask_q;
  logic       suppress_all_q;
  logic [9:0] tick_ms_q;

  // Sequencer control
  state_e        state_q, state_d;
  logic [CW-1:0] ch_q;
  logic [CHANNELS-1:0] valid_q, clr_q;

  // Latched request
  op_e              op_q;
  logic             ctrl_q;
  logic             ok_q;
  logic [AW-1:0]    idx_q;
  logic [DUR_W-1:0] dur_q;
  logic [STR_W-1:0] str_q;
  logic [CNT_W-1:0] cnt_q;
  logic [1:0]       pad_ready_q, accepted_q;

  // Output register
  logic             out_valid_q;
  logic             channel_q, send_q, high_q, ignored_q, last_q;
  logic [7:0]       level_q;
  logic [1:0]       mode_q;

  // Memory ports
  logic              ch_re, ch_we;
  logic [CW-1:0]     ch_raddr;
  logic [REC_W-1:0]  ch_rdata;
  logic              env_re, env_we;
  logic [ENV_AW-1:0] env_raddr, env_waddr;
  logic [ENT_W-1:0]  env_rdata;

  logic          in_fire, fire, last_ch, is_tick;
  logic [AW-1:0] idx_wrap;

  chan_rec_t        rec_eff, rec_new;
  logic [DUR_W-1:0] pend_dur;
  logic [STR_W-1:0] pend_str;
  logic             res_send, res_ign, rdy, ac, remaining_done;
  logic [DUR_W-1:0] p_dur_eff;
  logic [STR_W-1:0] p_str_eff;

  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_tick     = (op_q == OP_TICK);
  assign last_ch     = !is_tick || (ch_q == CW'(CHANNELS - 1));

  // Wrap the entry index into the envelope depth
  always_comb begin
    idx_wrap = '0;
    for (int j = 0; j < 16; j++) begin
      if (entry_index_i == 4'(j)) begin
        idx_wrap = AW'(j % ENVELOPE_DEPTH);
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CHAN;
      end
      ST_CHAN: state_d = ST_EXEC;
      ST_EXEC: begin
        if (fire) state_d = last_ch ? ST_IDLE : ST_CHAN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and memory read control
  always_comb begin
    in_ready_o = 1'b0;
    fire       = 1'b0;
    ch_re      = 1'b0;
    ch_raddr   = ch_q;
    env_re     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ch_re      = in_valid_i;
        ch_raddr   = (op_e'(operation_i) == OP_TICK) ? '0 : CW'(controller_i);
      end
      ST_CHAN: begin
        env_re = 1'b1;
      end
      ST_EXEC: begin
        fire     = !out_valid_q || out_ready_i;
        ch_re    = fire && !last_ch;
        ch_raddr = ch_q + CW'(1);
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Effective channel record: unwritten reads as zero, cleared fields as zero
  always_comb begin
    rec_eff = valid_q[ch_q] ? chan_rec_t'(ch_rdata) : '0;
    if (clr_q[ch_q]) begin
      rec_eff.mode      = MODE_OFF;
      rec_eff.remaining = '0;
      rec_eff.strength  = '0;
    end
  end

  assign env_raddr = {ch_q, rec_eff.next_entry};
  assign pend_dur  = rec_eff.from_pulse ? rec_eff.p_dur : env_rdata[ENT_W-1:STR_W];
  assign pend_str  = rec_eff.from_pulse ? rec_eff.p_str : env_rdata[STR_W-1:0];
  assign rdy       = (32'(ch_q) < 2) && pad_ready_q[ch_q[0]];
  assign ac        = (32'(ch_q) < 2) && accepted_q[ch_q[0]];
  assign remaining_done = rec_eff.remaining[REM_W-1] || (rec_eff.remaining == '0);
  assign p_dur_eff = (!enable_mask_q[ctrl_q] || suppress_all_q) ? '0 : dur_q;
  assign p_str_eff = (!enable_mask_q[ctrl_q] || suppress_all_q) ? '0 : str_q;

  // Modify the channel record for the current request
  always_comb begin
    rec_new  = rec_eff;
    res_send = 1'b0;
    res_ign  = 1'b0;
    unique case (op_q)
      OP_TICK: begin
        if (remaining_done) begin
          if (rec_eff.pending != '0) begin
            rec_new.remaining  = {1'b0, pend_dur};
            rec_new.strength   = pend_str;
            rec_new.mode       = (pend_str > STR_ON) ? MODE_SW_ON : MODE_SW_OFF;
            rec_new.pending    = rec_eff.pending - CNT_W'(1);
            rec_new.next_entry = (rec_eff.next_entry == AW'(ENVELOPE_DEPTH - 1)) ?
                                 '0 : rec_eff.next_entry + AW'(1);
          end else if (rec_eff.mode == MODE_SW_ON || rec_eff.mode == MODE_ON) begin
            rec_new.mode = MODE_SW_OFF;
          end
        end else begin
          rec_new.remaining = rec_eff.remaining - {7'd0, tick_ms_q};
        end
        if (rec_new.mode == MODE_SW_OFF) begin
          rec_new.levels = '0;
          res_send       = rdy;
          if (rdy && ac) rec_new.mode = MODE_OFF;
        end else if (rec_new.mode == MODE_SW_ON) begin
          rec_new.levels = levels_for(rec_new.strength);
          res_send       = rdy;
          if (rdy && ac) rec_new.mode = MODE_ON;
        end
      end
      OP_START: begin
        rec_new.next_entry = idx_q;
        rec_new.pending    = cnt_q;
        rec_new.from_pulse = 1'b0;
        rec_new.remaining  = '0;
      end
      OP_PULSE: begin
        if ((rec_eff.mode == MODE_SW_ON || rec_eff.mode == MODE_ON) &&
            (rec_eff.strength > p_str_eff ||
             (rec_eff.pending != '0 && pend_str > p_str_eff))) begin
          res_ign = 1'b1;
        end else begin
          rec_new.p_dur      = p_dur_eff;
          rec_new.p_str      = p_str_eff;
          rec_new.from_pulse = 1'b1;
          rec_new.pending    = CNT_W'(1);
          rec_new.remaining  = '0;
        end
      end
      OP_CLEAR: begin
        rec_new.mode      = MODE_OFF;
        rec_new.remaining = '0;
        rec_new.strength  = '0;
      end
      default: begin
        rec_new = rec_eff;
      end
    endcase
  end

  assign ch_we     = fire && ok_q;
  assign env_we    = fire && ok_q && (op_q == OP_WRITE);
  assign env_waddr = {ch_q, idx_q};

  // Channel state memory
  res_ram #(
    .WIDTH (REC_W),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_q),
    .wdata_i (REC_W'(rec_new)),
    .re_i    (ch_re),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  // Envelope store, one region per channel
  res_ram #(
    .WIDTH (ENT_W),
    .DEPTH (2 ** ENV_AW)
  ) u_env_ram (
    .clk_i   (clk_i),
    .we_i    (env_we),
    .waddr_i (env_waddr),
    .wdata_i ({dur_q, str_q}),
    .re_i    (env_re),
    .raddr_i (env_raddr),
    .rdata_o (env_rdata)
  );

  // Control state, configuration and record flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      ch_q           <= '0;
      valid_q        <= '0;
      clr_q          <= '0;
      enable_mask_q  <= 2'd3;
      suppress_all_q <= 1'b0;
      tick_ms_q      <= 10'd30;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        ch_q <= (op_e'(operation_i) == OP_TICK) ? '0 : CW'(controller_i);
      end else if (fire && !last_ch) begin
        ch_q <= ch_q + CW'(1);
      end
      if (ch_we) begin
        valid_q[ch_q] <= 1'b1;
      end
      if (fire && op_q == OP_CLEAR) begin
        clr_q <= '1;
      end else if (ch_we) begin
        clr_q[ch_q] <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_ENABLE_MASK:  enable_mask_q  <= cfg_data_i[1:0];
          CFG_SUPPRESS_ALL: suppress_all_q <= cfg_data_i[0];
          CFG_TICK_MS:      tick_ms_q      <= cfg_data_i;
          default:          tick_ms_q      <= tick_ms_q;
        endcase
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the request payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q        <= op_e'(operation_i);
      ctrl_q      <= controller_i;
      ok_q        <= (op_e'(operation_i) == OP_TICK) || (32'(controller_i) < CHANNELS);
      idx_q       <= idx_wrap;
      dur_q       <= duration_ms_i;
      str_q       <= strength_i;
      cnt_q       <= entry_count_i;
      pad_ready_q <= pad_ready_i;
      accepted_q  <= accepted_i;
    end
  end

  // Load the result
  always_ff @(posedge clk_i) begin
    if (fire) begin
      channel_q <= ch_q[0];
      send_q    <= res_send;
      ignored_q <= res_ign;
      last_q    <= last_ch;
      high_q    <= ok_q ? rec_new.levels[8] : 1'b0;
      level_q   <= ok_q ? rec_new.levels[7:0] : 8'd0;
      mode_q    <= ok_q ? rec_new.mode : MODE_OFF;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_o     = channel_q;
  assign send_o        = send_q;
  assign high_motor_o  = high_q;
  assign motor_level_o = level_q;
  assign mode_o        = mode_q;
  assign ignored_o     = ignored_q;
  assign last_o        = last_q;

  // Write-back never collides with the read of the next channel
  a_no_rw_collision : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ch_we && ch_re |-> ch_q != ch_raddr)
    else $error("channel RAM read and write hit one entry");

  // Envelope write and read are never issued together
  a_env_port : assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_we |-> !env_re)
    else $error("envelope RAM read during write");

  // An accepted request always starts with a channel read
  a_accept_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> ch_re ##1 state_q == ST_CHAN)
    else $error("request accepted without channel read");

  // A stalled result keeps the sequencer and its channel
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC && !fire |=> state_q == ST_EXEC && $stable(ch_q))
    else $error("sequencer moved while result stalled");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench
  import res_pkg::*;
();

  // Operation codes the block has no meaning for
  localparam logic [2:0] OP_UNDEFINED_LO = 3'd5;
  localparam logic [2:0] OP_UNDEFINED_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_LIMIT   = 5000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned HOLD_TRIGGER  = 120;
  localparam int unsigned PHASES        = 7;

  typedef struct packed {
    logic [2:0]       op;
    logic             controller;
    logic [3:0]       index;
    logic [DUR_W-1:0] duration;
    logic [STR_W-1:0] strength;
    logic [CNT_W-1:0] count;
    logic [1:0]       pad_ready;
    logic [1:0]       accepted;
  } rumble_request_t;

  typedef struct packed {
    logic       channel;
    logic       send;
    logic       high_motor;
    logic [7:0] level;
    mode_e      mode;
    logic       ignored;
    logic       last;
  } rumble_command_t;

  // Channel model of the sequencer plus the queue of commands it predicts
  class rumble_checker;
    localparam int unsigned FULL_SCALE     = 4096;
    localparam int unsigned HIGH_THRESHOLD = 3276;
    localparam int unsigned ON_THRESHOLD   = 204;

    logic [1:0]       enable_mask;
    logic             suppress;
    logic [9:0]       tick_ms;

    mode_e            chan_mode [2];
    int               remaining [2];
    logic [STR_W-1:0] cur_strength [2];
    logic [CNT_W-1:0] pending [2];
    logic [3:0]       next_idx [2];
    logic             from_pulse [2];
    logic [DUR_W-1:0] pulse_dur [2];
    logic [STR_W-1:0] pulse_str [2];
    logic [DUR_W-1:0] env_dur [2][16];
    logic [STR_W-1:0] env_str [2][16];
    logic [8:0]       levels [2];

    rumble_command_t  expected_commands [$];
    int unsigned      mismatches;
    int unsigned      checked;

    function new();
      enable_mask = 2'b11;
      suppress    = 1'b0;
      tick_ms     = 10'd30;
      for (int k = 0; k < 2; k++) begin
        chan_mode[k]    = MODE_OFF;
        remaining[k]    = 0;
        cur_strength[k] = '0;
        pending[k]      = '0;
        next_idx[k]     = '0;
        from_pulse[k]   = 1'b0;
        pulse_dur[k]    = '0;
        pulse_str[k]    = '0;
        levels[k]       = '0;
      end
      mismatches = 0;
      checked    = 0;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) begin
        $display("mismatch at %0t: %s", $time, msg);
      end
    endtask

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_ENABLE_MASK:  enable_mask = data[1:0];
        CFG_SUPPRESS_ALL: suppress    = data[0];
        CFG_TICK_MS:      tick_ms     = data[9:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending_results();
      return expected_commands.size();
    endfunction

    // Actuator bytes {high motor, level} for a Q12 intensity
    function logic [8:0] level_bytes(logic [STR_W-1:0] s);
      int unsigned i;
      int unsigned lvl;
      logic        high;
      i    = (s > FULL_SCALE) ? FULL_SCALE : s;
      high = (s > HIGH_THRESHOLD);
      if (high) begin
        lvl = ((5 * i - 4096) * 255) >> 14;
      end else begin
        lvl = (i * 1275) >> 14;
      end
      if (lvl > 255) begin
        lvl = 255;
      end
      return {high, lvl[7:0]};
    endfunction

    function logic [STR_W-1:0] queued_strength(int c);
      return from_pulse[c] ? pulse_str[c] : env_str[c][next_idx[c]];
    endfunction

    function logic [DUR_W-1:0] queued_duration(int c);
      return from_pulse[c] ? pulse_dur[c] : env_dur[c][next_idx[c]];
    endfunction

    function void push_command(int c, logic send, logic ign, logic last);
      rumble_command_t cmd;
      cmd.channel    = c[0];
      cmd.send       = send;
      cmd.high_motor = levels[c][8];
      cmd.level      = levels[c][7:0];
      cmd.mode       = chan_mode[c];
      cmd.ignored    = ign;
      cmd.last       = last;
      expected_commands.push_back(cmd);
    endfunction

    // Advance the channel model by one accepted request
    function void note_request(rumble_request_t req);
      int               c;
      logic             send;
      logic             ign;
      logic [DUR_W-1:0] d;
      logic [STR_W-1:0] s;
      c   = int'(req.controller);
      ign = 1'b0;
      if (req.op == OP_TICK) begin
        for (int k = 0; k < 2; k++) begin
          send = 1'b0;
          // count down, or load the next entry once time has run out
          if (remaining[k] <= 0) begin
            if (pending[k] != 0) begin
              remaining[k]    = int'(queued_duration(k));
              cur_strength[k] = queued_strength(k);
              chan_mode[k]    = (cur_strength[k] > ON_THRESHOLD) ? MODE_SW_ON : MODE_SW_OFF;
              pending[k]--;
              next_idx[k]++;
            end else if (chan_mode[k] == MODE_SW_ON || chan_mode[k] == MODE_ON) begin
              chan_mode[k] = MODE_SW_OFF;
            end
          end else begin
            remaining[k] -= int'(tick_ms);
          end
          // present the switch command and settle on acceptance
          if (chan_mode[k] == MODE_SW_OFF) begin
            levels[k] = '0;
            if (req.pad_ready[k]) begin
              send = 1'b1;
              if (req.accepted[k]) chan_mode[k] = MODE_OFF;
            end
          end else if (chan_mode[k] == MODE_SW_ON) begin
            levels[k] = level_bytes(cur_strength[k]);
            if (req.pad_ready[k]) begin
              send = 1'b1;
              if (req.accepted[k]) chan_mode[k] = MODE_ON;
            end
          end
          push_command(k, send, 1'b0, k == 1);
        end
        return;
      end
      case (req.op)
        OP_CLEAR: begin
          for (int k = 0; k < 2; k++) begin
            chan_mode[k]    = MODE_OFF;
            remaining[k]    = 0;
            cur_strength[k] = '0;
          end
        end
        OP_WRITE: begin
          env_dur[c][req.index] = req.duration;
          env_str[c][req.index] = req.strength;
        end
        OP_START: begin
          next_idx[c]   = req.index;
          pending[c]    = req.count;
          from_pulse[c] = 1'b0;
          remaining[c]  = 0;
        end
        OP_PULSE: begin
          d = req.duration;
          s = req.strength;
          if (!enable_mask[c] || suppress) begin
            d = '0;
            s = '0;
          end
          // drop a weaker pulse while a stronger one plays or waits
          if ((chan_mode[c] == MODE_SW_ON || chan_mode[c] == MODE_ON) &&
              (cur_strength[c] > s || (pending[c] != 0 && queued_strength(c) > s))) begin
            ign = 1'b1;
          end else begin
            pulse_dur[c]  = d;
            pulse_str[c]  = s;
            from_pulse[c] = 1'b1;
            pending[c]    = CNT_W'(1);
            remaining[c]  = 0;
          end
        end
        default: ;
      endcase
      push_command(c, 1'b0, ign, 1'b1);
    endfunction

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("command %0d %s: got %0h, expected %0h", checked, name, got, want));
      end
    endtask

    task check_command(rumble_command_t got);
      rumble_command_t want;
      if (expected_commands.size() == 0) begin
        report($sformatf("command on channel %0d with none expected", got.channel));
        return;
      end
      want = expected_commands.pop_front();
      compare_field("channel", 8'(got.channel), 8'(want.channel));
      compare_field("send", 8'(got.send), 8'(want.send));
      compare_field("high_motor", 8'(got.high_motor), 8'(want.high_motor));
      compare_field("motor_level", got.level, want.level);
      compare_field("mode", 8'(got.mode), 8'(want.mode));
      compare_field("ignored", 8'(got.ignored), 8'(want.ignored));
      compare_field("last", 8'(got.last), 8'(want.last));
      checked++;
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [2:0]            operation_i = '0;
  logic                  controller_i = 1'b0;
  logic [3:0]            entry_index_i = '0;
  logic [DUR_W-1:0]      duration_ms_i = '0;
  logic [STR_W-1:0]      strength_i = '0;
  logic [CNT_W-1:0]      entry_count_i = '0;
  logic [1:0]            pad_ready_i = '0;
  logic [1:0]            accepted_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  channel_o;
  logic                  send_o;
  logic                  high_motor_o;
  logic [7:0]            motor_level_o;
  logic [1:0]            mode_o;
  logic                  ignored_o;
  logic                  last_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  rumble_checker   sb;
  rumble_command_t observed;
  logic [15:0]     entry_written [2] = '{16'h0, 16'h0};
  int unsigned     requests_accepted = 0;
  int unsigned     tick_setting = 30;
  int unsigned     cycle_count = 0;

  rumble_envelope_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .controller_i  (controller_i),
    .entry_index_i (entry_index_i),
    .duration_ms_i (duration_ms_i),
    .strength_i    (strength_i),
    .entry_count_i (entry_count_i),
    .pad_ready_i   (pad_ready_i),
    .accepted_i    (accepted_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .channel_o     (channel_o),
    .send_o        (send_o),
    .high_motor_o  (high_motor_o),
    .motor_level_o (motor_level_o),
    .mode_o        (mode_o),
    .ignored_o     (ignored_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a run that exceeds the overall cycle limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // Check every accepted command against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      observed.channel    = channel_o;
      observed.send       = send_o;
      observed.high_motor = high_motor_o;
      observed.level      = motor_level_o;
      observed.mode       = mode_e'(mode_o);
      observed.ignored    = ignored_o;
      observed.last       = last_o;
      sb.check_command(observed);
    end
  end

  // Stall the command side in changing patterns, with one long hold-off
  initial begin : receiver
    int unsigned hold_left;
    int unsigned pattern_left;
    int unsigned pattern;
    bit          hold_done;
    hold_left    = 0;
    pattern_left = 0;
    pattern      = 0;
    hold_done    = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && requests_accepted >= HOLD_TRIGGER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern      = $urandom_range(0, 3);
          pattern_left = $urandom_range(20, 120);
        end
        pattern_left--;
        case (pattern)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 1) == 0);
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic rumble_request_t make_request(logic [2:0] op, logic c, logic [3:0] idx,
                                                   logic [DUR_W-1:0] dur,
                                                   logic [STR_W-1:0] str,
                                                   logic [CNT_W-1:0] cnt,
                                                   logic [1:0] rdy, logic [1:0] acc);
    rumble_request_t req;
    req.op         = op;
    req.controller = c;
    req.index      = idx;
    req.duration   = dur;
    req.strength   = str;
    req.count      = cnt;
    req.pad_ready  = rdy;
    req.accepted   = acc;
    return req;
  endfunction

  // Number of consecutive written entries from idx, so a start never reads garbage
  function automatic int unsigned written_run(logic c, logic [3:0] idx);
    int unsigned n;
    logic [3:0]  at;
    n  = 0;
    at = idx;
    while (n < 16 && entry_written[c][at]) begin
      n++;
      at++;
    end
    return n;
  endfunction

  function automatic logic [DUR_W-1:0] pick_duration();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return DUR_W'($urandom);
    if (r < 10) return '0;
    return DUR_W'($urandom_range(0, 4 * tick_setting + 10));
  endfunction

  function automatic logic [STR_W-1:0] pick_strength();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 18) return 13'd4096;
    if (r < 26) return STR_W'($urandom_range(200, 208));
    if (r < 34) return STR_W'($urandom_range(3272, 3280));
    return STR_W'($urandom_range(0, 4096));
  endfunction

  function automatic rumble_request_t random_request();
    rumble_request_t req;
    int unsigned     pick;
    int unsigned     run;
    req.op         = OP_TICK;
    req.controller = 1'($urandom_range(0, 1));
    req.index      = 4'($urandom_range(0, 15));
    req.duration   = pick_duration();
    req.strength   = pick_strength();
    req.count      = CNT_W'($urandom_range(0, 16));
    req.pad_ready  = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : 2'b11;
    req.accepted   = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      req.op = OP_TICK;
    end else if (pick < 63) begin
      req.op = OP_WRITE;
    end else if (pick < 73) begin
      req.op    = OP_START;
      run       = written_run(req.controller, req.index);
      req.count = ($urandom_range(0, 1) == 0) ? CNT_W'(run) : CNT_W'($urandom_range(0, run));
    end else if (pick < 88) begin
      req.op = OP_PULSE;
    end else if (pick < 93) begin
      req.op = OP_CLEAR;
    end else begin
      req.op = 3'($urandom_range(OP_UNDEFINED_LO, OP_UNDEFINED_HI));
    end
    return req;
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_request(input rumble_request_t req);
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    operation_i   <= req.op;
    controller_i  <= req.controller;
    entry_index_i <= req.index;
    duration_ms_i <= req.duration;
    strength_i    <= req.strength;
    entry_count_i <= req.count;
    pad_ready_i   <= req.pad_ready;
    accepted_i    <= req.accepted;
    if (req.op == OP_WRITE) begin
      entry_written[req.controller][req.index] = 1'b1;
    end
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
    requests_accepted++;
  endtask

  task automatic pause_sender(input int unsigned idle_cycles);
    if (idle_cycles != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (idle_cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                input logic [CFG_DATA_W-1:0] reg_value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_index;
    cfg_data_i  <= reg_value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(reg_index, reg_value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every predicted command, then let the pipeline settle
  task automatic wait_for_drain();
    int unsigned waited;
    waited = 0;
    while (sb.pending_results() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Send requests in bursts separated by random gaps
  task automatic run_random(input int unsigned total);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < total) begin
      burst = $urandom_range(1, 24);
      while (burst != 0 && sent < total) begin
        send_request(random_request());
        burst--;
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end
    pause_sender(1);
  endtask

  initial begin
    logic [1:0]  phase_mask [PHASES];
    logic        phase_suppress [PHASES];
    int unsigned phase_tick [PHASES];
    int unsigned phase_items [PHASES];
    phase_mask     = '{2'd3, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0};
    phase_suppress = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_tick     = '{30, 1000, 1, 500, 0, 1, 30};
    phase_items    = '{200, 180, 200, 180, 60, 220, 200};
    sb = new();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme entries, wrapped envelopes, every operation, pad handshakes
    send_request(make_request(OP_WRITE, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_WRITE, 1'b0, 4'd1, 16'hffff, 13'd4096, 5'd16, 2'd3, 2'd3));
    send_request(make_request(OP_WRITE, 1'b0, 4'd2, 16'd45, 13'd3277, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_WRITE, 1'b0, 4'd15, 16'd60, 13'd205, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_WRITE, 1'b1, 4'd0, 16'd31, 13'd204, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_WRITE, 1'b1, 4'd15, 16'd1, 13'd3276, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_START, 1'b0, 4'd15, 16'd0, 13'd0, 5'd3, 2'd0, 2'd0));
    send_request(make_request(OP_START, 1'b1, 4'd15, 16'd0, 13'd0, 5'd2, 2'd0, 2'd0));
    send_request(make_request(OP_TICK, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd3, 2'd0));
    send_request(make_request(OP_TICK, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd3, 2'd3));
    send_request(make_request(OP_TICK, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd0, 2'd3));
    send_request(make_request(OP_TICK, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd2, 2'd1));
    send_request(make_request(OP_PULSE, 1'b0, 4'd0, 16'd100, 13'd100, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_PULSE, 1'b1, 4'd0, 16'd0, 13'd4096, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_TICK, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd3, 2'd3));
    send_request(make_request(OP_CLEAR, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_TICK, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd3, 2'd3));
    send_request(make_request(OP_UNDEFINED_HI, 1'b1, 4'd0, 16'd0, 13'd0, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_UNDEFINED_LO, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_START, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_TICK, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd1, 2'd2));
    send_request(make_request(OP_PULSE, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd0, 2'd0));
    send_request(make_request(OP_TICK, 1'b0, 4'd0, 16'd0, 13'd0, 5'd0, 2'd3, 2'd3));
    pause_sender(1);

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_for_drain();
      if (p == PHASES - 1) begin
        phase_mask[p]     = 2'($urandom_range(0, 3));
        phase_suppress[p] = 1'($urandom_range(0, 1));
        phase_tick[p]     = $urandom_range(1, 1000);
      end
      tick_setting = phase_tick[p];
      write_register(CFG_ENABLE_MASK, CFG_DATA_W'(phase_mask[p]));
      write_register(CFG_SUPPRESS_ALL, CFG_DATA_W'(phase_suppress[p]));
      write_register(CFG_TICK_MS, CFG_DATA_W'(phase_tick[p]));
      run_random(phase_items[p]);
    end

    wait_for_drain();
    if (sb.pending_results() != 0) begin
      sb.report($sformatf("%0d commands never arrived", sb.pending_results()));
    end
    if (sb.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
